/* hw/rtl/ewsm_pkg.sv */
// Shared types and constants of the energy window stabilization monitor.
package ewsm_pkg;

  localparam int E_W     = 40;  // stored energy, signed Q32.8
  localparam int VAL_W   = 32;  // contribution, signed Q24.8
  localparam int STAB_W  = 17;  // stabilization, unsigned Q1.16
  localparam int LB_W    = 8;
  localparam int ACC_W   = E_W + 2;  // sum of three ring entries
  localparam int DIFF_W  = E_W + 4;  // 3*last minus that sum
  localparam int MAG_W   = DIFF_W - 1;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 104;

  // Reciprocal numerator 65536 * 768 and its long-division schedule.
  localparam int DIV_NW = 26;
  localparam int DIV_CW = 5;
  localparam logic [DIV_NW-1:0] DIV_NUM = 26'd50331648;

  localparam logic [MAG_W-1:0]  DIST_MIN  = MAG_W'(768);
  localparam logic [STAB_W-1:0] STAB_ONE  = 17'd65536;
  localparam logic [LB_W-1:0]   LB_RESET  = 8'd200;
  localparam int                LB_MID    = 10;
  localparam int                LB_NEAR   = 20;

  localparam logic signed [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
  localparam logic signed [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

  localparam logic KIND_ACC   = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  // Configuration port.
  localparam int         CFG_AW       = 3;
  localparam logic [0:0] REG_LOOKBACK = 1'b0;

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int QPW     = 1;
  localparam int QCW     = 2;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

/* hw/rtl/ewsm_front.sv */
// Input side: takes beats, classifies them into commands and queues them.
module ewsm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                enable_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [0:0]                          s_axis_tuser,  // kind
  input  logic [ewsm_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // value[31:0]
  output logic                                cmd_valid_o,
  output ewsm_pkg::cmd_t                      cmd_o,
  input  logic                                cmd_pop_i
);

  ewsm_pkg::cmd_t                 q_mem [ewsm_pkg::Q_DEPTH];
  logic [ewsm_pkg::QPW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ewsm_pkg::QPW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ewsm_pkg::QCW-1:0]       cnt_q, cnt_d;
  logic                           push;
  ewsm_pkg::cmd_t                 cmd_in;

  assign s_axis_tready = enable_i && (cnt_q != ewsm_pkg::QCW'(ewsm_pkg::Q_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != '0);
  assign cmd_o         = q_mem[rd_ptr_q];

  always_comb begin
    cmd_in.kind  = (s_axis_tuser[0] == ewsm_pkg::KIND_STORE) ? ewsm_pkg::KIND_STORE
                                                              : ewsm_pkg::KIND_ACC;
    cmd_in.value = $signed(s_axis_tdata[ewsm_pkg::VAL_W-1:0]);
    wr_ptr_d = push ? ewsm_pkg::QPW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ewsm_pkg::QPW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = ewsm_pkg::QCW'(cnt_q + 1'b1);
    end else if (!push && cmd_pop_i) begin
      cnt_d = ewsm_pkg::QCW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* hw/rtl/ewsm_div.sv */
// Restoring divider: 65536*768 divided by the energy distance, one bit a cycle.
module ewsm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ewsm_pkg::MAG_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [ewsm_pkg::STAB_W-1:0]   quot_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [ewsm_pkg::DIV_CW-1:0]     cnt_q, cnt_d;
  logic [ewsm_pkg::MAG_W-1:0]      dvs_q, dvs_d;
  logic [ewsm_pkg::MAG_W-1:0]      rem_q, rem_d;
  logic [ewsm_pkg::DIV_NW-1:0]     num_q, num_d;
  logic [ewsm_pkg::DIV_NW-1:0]     quot_q, quot_d;
  logic [ewsm_pkg::MAG_W:0]        trial;
  logic                            ge;

  assign trial  = {rem_q, num_q[ewsm_pkg::DIV_NW-1]};
  assign ge     = (trial >= {1'b0, dvs_q});
  assign done_o = done_q;
  assign quot_o = quot_q[ewsm_pkg::STAB_W-1:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvs_d  = divisor_i;
      rem_d  = '0;
      num_d  = ewsm_pkg::DIV_NUM;
      quot_d = '0;
    end else if (busy_q) begin
      // The remainder always stays below the divisor, so it fits MAG_W bits.
      rem_d  = ge ? ewsm_pkg::MAG_W'(trial - {1'b0, dvs_q}) : trial[ewsm_pkg::MAG_W-1:0];
      num_d  = {num_q[ewsm_pkg::DIV_NW-2:0], 1'b0};
      quot_d = {quot_q[ewsm_pkg::DIV_NW-2:0], ge};
      cnt_d  = ewsm_pkg::DIV_CW'(cnt_q + 1'b1);
      if (cnt_q == ewsm_pkg::DIV_CW'(ewsm_pkg::DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* hw/rtl/ewsm_back.sv */
// Execution side: energy state, ring memory, stabilization sequencer, result register.
module ewsm_back #(
  parameter int RING_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ewsm_pkg::LB_W-1:0]           lookback_i,
  input  logic                                cmd_valid_i,
  input  ewsm_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  output logic                                init_done_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ewsm_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int SUMW = ewsm_pkg::E_W + AW;
  localparam int SW   = ((AW > ewsm_pkg::LB_W) ? AW : ewsm_pkg::LB_W) + 2;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RDOLD  = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_DIFF   = 3'd4;
  localparam logic [2:0] ST_ABS    = 3'd5;
  localparam logic [2:0] ST_DIV    = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic signed [ewsm_pkg::E_W-1:0]     ring_mem [RING_DEPTH];
  logic signed [ewsm_pkg::E_W-1:0]     rd_data_q;

  logic [2:0]                          state_q, state_d;
  logic [AW-1:0]                       clr_idx_q, clr_idx_d;
  logic [AW-1:0]                       pos_q, pos_d;
  logic signed [ewsm_pkg::E_W-1:0]     partial_q, partial_d;
  logic signed [SUMW-1:0]              sum_q, sum_d;
  logic signed [ewsm_pkg::E_W-1:0]     last_q, last_d;
  logic [ewsm_pkg::STAB_W-1:0]         stab_q, stab_d;
  logic signed [ewsm_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic signed [ewsm_pkg::DIFF_W-1:0]  diff_q, diff_d;
  logic [1:0]                          rd_cnt_q, rd_cnt_d;
  logic                                out_valid_q, out_valid_d;
  logic [ewsm_pkg::TDATA_OUT_W-1:0]    out_data_q, out_data_d;

  logic                                mem_we, mem_re;
  logic [AW-1:0]                       mem_waddr, mem_raddr;
  logic signed [ewsm_pkg::E_W-1:0]     mem_wdata;

  logic                                slot_free;
  logic                                load_out;
  logic signed [ewsm_pkg::E_W:0]       acc_sum;
  logic signed [ewsm_pkg::E_W-1:0]     acc_sat;
  logic signed [SW-1:0]                steps;
  logic [AW-1:0]                       offset;
  logic [AW-1:0]                       lb_addr;
  logic signed [ewsm_pkg::DIFF_W-1:0]  diff_abs;
  logic [ewsm_pkg::MAG_W-1:0]          mag;
  logic signed [SUMW-1:0]              avg_full;
  logic                                div_start, div_done;
  logic [ewsm_pkg::STAB_W-1:0]         div_quot;

  ewsm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (mag),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign init_done_o   = (state_q != ST_CLEAR);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign slot_free     = !out_valid_q || m_axis_tready;

  // Saturating accumulate into the partial energy.
  assign acc_sum = (ewsm_pkg::E_W+1)'(partial_q) + (ewsm_pkg::E_W+1)'($signed(cmd_i.value));
  always_comb begin
    if (acc_sum[ewsm_pkg::E_W] != acc_sum[ewsm_pkg::E_W-1]) begin
      acc_sat = acc_sum[ewsm_pkg::E_W] ? ewsm_pkg::E_MIN : ewsm_pkg::E_MAX;
    end else begin
      acc_sat = acc_sum[ewsm_pkg::E_W-1:0];
    end
  end

  // Ring address of the compared entry selected by the read counter. A short
  // lookback goes negative and wraps ahead of the current position.
  always_comb begin
    case (rd_cnt_q)
      2'd1:    steps = $signed(SW'(lookback_i)) - SW'(ewsm_pkg::LB_MID);
      2'd2:    steps = $signed(SW'(lookback_i)) - SW'(ewsm_pkg::LB_NEAR);
      default: steps = $signed(SW'(lookback_i));
    endcase
    if (int'(steps) >= RING_DEPTH) begin
      offset = AW'(RING_DEPTH - 1);
    end else begin
      offset = steps[AW-1:0];
    end
    lb_addr = AW'(pos_q - offset);
  end

  assign diff_abs = diff_q[ewsm_pkg::DIFF_W-1] ? -diff_q : diff_q;
  assign mag      = diff_abs[ewsm_pkg::MAG_W-1:0];
  assign avg_full = sum_q >>> AW;

  always_comb begin
    state_d    = state_q;
    clr_idx_d  = clr_idx_q;
    pos_d      = pos_q;
    partial_d  = partial_q;
    sum_d      = sum_q;
    last_d     = last_q;
    stab_d     = stab_q;
    acc_d      = acc_q;
    diff_d     = diff_q;
    rd_cnt_d   = rd_cnt_q;
    cmd_pop_o  = 1'b0;
    load_out   = 1'b0;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pos_q;
    mem_wdata  = partial_q;
    mem_re     = 1'b0;
    mem_raddr  = lb_addr;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
        clr_idx_d = AW'(clr_idx_q + 1'b1);
        if (clr_idx_q == AW'(RING_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == ewsm_pkg::KIND_ACC) begin
            partial_d = acc_sat;
            load_out  = 1'b1;
          end else begin
            pos_d     = AW'(pos_q + 1'b1);
            mem_re    = 1'b1;
            mem_raddr = AW'(pos_q + 1'b1);
            state_d   = ST_RDOLD;
          end
        end
      end
      ST_RDOLD: begin
        // The entry leaving the window is in rd_data_q; replace it.
        sum_d     = sum_q - SUMW'(rd_data_q) + SUMW'(partial_q);
        mem_we    = 1'b1;
        last_d    = partial_q;
        partial_d = '0;
        acc_d     = '0;
        rd_cnt_d  = '0;
        state_d   = ST_READ;
      end
      ST_READ: begin
        if (rd_cnt_q != 2'd3) begin
          mem_re = 1'b1;
        end
        if (rd_cnt_q != 2'd0) begin
          acc_d = acc_q + ewsm_pkg::ACC_W'(rd_data_q);
        end
        rd_cnt_d = 2'(rd_cnt_q + 1'b1);
        if (rd_cnt_q == 2'd3) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_d  = ewsm_pkg::DIFF_W'(last_q) + (ewsm_pkg::DIFF_W'(last_q) <<< 1)
                  - ewsm_pkg::DIFF_W'(acc_q);
        state_d = ST_ABS;
      end
      ST_ABS: begin
        if (mag < ewsm_pkg::DIST_MIN) begin
          stab_d  = ewsm_pkg::STAB_ONE;
          state_d = ST_FINISH;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          stab_d  = div_quot;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {{(ewsm_pkg::TDATA_OUT_W - 2*ewsm_pkg::E_W - ewsm_pkg::STAB_W){1'b0}},
                     stab_q, avg_full[ewsm_pkg::E_W-1:0], last_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= ring_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    diff_q     <= diff_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      pos_q       <= '0;
      partial_q   <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      stab_q      <= ewsm_pkg::STAB_ONE;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      pos_q       <= pos_d;
      partial_q   <= partial_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      stab_q      <= stab_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/energy_window_stabilization_monitor_top.sv */
// Top level of the energy window stabilization monitor.
//
// Input stream: one beat per item. tuser[0] is the kind (0 adds the signed
// Q24.8 value in tdata[31:0] to the partial energy, 1 stores the partial
// energy into the ring of RING_DEPTH energies). Every beat yields exactly one
// output beat carrying last energy, window average and stabilization.
// Configuration: APB register 0 (address 0) holds lookback_steps[7:0].
//
// Accepted beats enter a two-entry command queue; the execution side takes
// one command at a time. An accumulate beat is executed straight from the
// idle state, and its output beat is valid after the next clock edge. A store
// beat takes one ring read of the outgoing entry, its replacement, three ring
// reads through the single read port, the distance computation and a 26-step
// bit-serial reciprocal division. A distance below 3.0 (768 in Q.8) skips the
// division.
//
// After reset the ring memory is swept to zero, one entry a cycle, over all
// RING_DEPTH entries; s_axis_tready stays low during that sweep. When the
// output receiver stalls, the result is held in the output register, the
// execution side waits, and the queue fills until s_axis_tready drops.
module energy_window_stabilization_monitor_top #(
  parameter int RING_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [0:0]                          s_axis_tuser,  // kind
  input  logic [ewsm_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // value[31:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // last_energy[39:0], average_energy[79:40], stabilization[96:80], zero pad
  output logic [ewsm_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ewsm_pkg::CFG_AW-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [ewsm_pkg::LB_W-1:0]   lookback_q, lookback_d;
  logic                        cfg_hit;
  logic                        init_done;
  logic                        cmd_valid;
  logic                        cmd_pop;
  ewsm_pkg::cmd_t              cmd;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ewsm_pkg::CFG_AW-1] == ewsm_pkg::REG_LOOKBACK);
  assign prdata  = cfg_hit ? 32'(lookback_q) : '0;

  always_comb begin
    lookback_d = lookback_q;
    if (psel && penable && pwrite && pready && cfg_hit) begin
      lookback_d = pwdata[ewsm_pkg::LB_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookback_q <= ewsm_pkg::LB_RESET;
    end else begin
      lookback_q <= lookback_d;
    end
  end

  ewsm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .enable_i      (init_done),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  ewsm_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lookback_i    (lookback_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .init_done_o   (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // No beat may be taken while the ring is still being cleared.
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !s_axis_tready)
    else $error("input beat accepted during ring clearing");

  // The execution side only pops commands that exist.
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  // The stabilization figure never exceeds 1.0 and the pad bits stay clear.
  a_stab_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[96:80] <= ewsm_pkg::STAB_ONE) &&
                      (m_axis_tdata[103:97] == '0))
    else $error("stabilization out of range");

endmodule
